[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros shared by the rtl; clk and rst_n must be in scope
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked outside reset
`define AP_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define AP_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AP_IMPL(lbl, ante, cons, msg)
`define AP_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hdl/atpr_pkg.sv]
// ---------------------------------------------------------------------------
// atpr_pkg
// widths, constants and the arctangent table of the tilt angle pipeline
// ---------------------------------------------------------------------------
package atpr_pkg;

    // port payload widths
    localparam int ACCEL_W = 16;
    localparam int ANGLE_W = 15;

    // internal widths
    localparam int NUM_W   = 17;   // numerator, holds +32768
    localparam int SQ_W    = 32;   // sum of two squares
    localparam int ROOT_W  = 31;   // floor sqrt of sum << 30
    localparam int REM_W   = 33;   // square root partial remainder
    localparam int CRD_W   = 35;   // cordic x and y
    localparam int ACC_W   = 28;   // angle accumulator, micro-degrees
    localparam int MAG_W   = 27;   // rounded accumulator magnitude
    localparam int PROD_W  = 54;   // magnitude times reciprocal
    localparam int QUO_W   = 14;   // hundredths of a degree, unsigned

    localparam int SQRT_STEPS = 31;
    localparam int ATAN_LEN   = 24;
    localparam int Y_SHIFT    = 15;

    // rounding to hundredths of a degree
    localparam int ANGLE_LIMIT  = 9000;
    localparam int UDEG_PER_LSB = 10000;
    localparam int ROUND_HALF   = 5000;
    localparam int RECIP_SHIFT  = 40;
    localparam logic [MAG_W-1:0] RECIP = 27'd109951162;  // floor(2^40 / 10000)

    typedef logic signed [ACC_W-1:0] udeg_t;

    // atan(2^-i) in micro-degrees
    localparam udeg_t ATAN_UDEG [ATAN_LEN] = '{
        28'sd45000000, 28'sd26565051, 28'sd14036243, 28'sd7125016,
        28'sd3576334,  28'sd1789911,  28'sd895174,   28'sd447614,
        28'sd223811,   28'sd111906,   28'sd55953,    28'sd27976,
        28'sd13988,    28'sd6994,     28'sd3497,     28'sd1749,
        28'sd874,      28'sd437,      28'sd219,      28'sd109,
        28'sd55,       28'sd27,       28'sd14,       28'sd7
    };

    // control that rides along with each sample
    typedef struct packed {
        logic valid;
        logic num_zero;
        logic sq_zero;
        logic num_neg;
    } tag_t;

endpackage

[hdl/atpr_if.sv]
// ---------------------------------------------------------------------------
// atpr_if
// valid/ready channels: raw accelerometer sample in, tilt angles out
// ---------------------------------------------------------------------------
interface atpr_sample_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [atpr_pkg::ACCEL_W-1:0]  accel_x;
    logic signed [atpr_pkg::ACCEL_W-1:0]  accel_y;
    logic signed [atpr_pkg::ACCEL_W-1:0]  accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);

endinterface

interface atpr_angle_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [atpr_pkg::ANGLE_W-1:0]  pitch_angle;
    logic signed [atpr_pkg::ANGLE_W-1:0]  roll_angle;

    modport source (output valid, output pitch_angle, output roll_angle, input ready);
    modport sink   (input valid, input pitch_angle, input roll_angle, output ready);

endinterface

[hdl/accel_tilt_pitch_roll.sv]
// pipeline: two square stages, 31 square root stages, CORDIC_STAGES cordic stages (capped at
// the arctangent table length) and four rounding stages, the last being the output register
// throughput: one request per cycle; a held output freezes the whole pipeline
// reset: asynchronous, clears every valid bit; no clearing pass is needed
// ---------------------------------------------------------------------------
// accel_tilt_pitch_roll
// pitch and roll in hundredths of a degree from one raw three-axis sample
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module accel_tilt_pitch_roll #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    atpr_sample_if.sink         sample,
    atpr_angle_if.source        angle
);

    localparam int NUM_W = atpr_pkg::NUM_W;

    logic                             en;
    logic                             pitch_valid, roll_valid;
    logic signed [NUM_W-1:0]          pitch_num, roll_num;

    // pipeline advances unless a finished result is held
    assign en           = !pitch_valid || angle.ready;
    assign sample.ready = en;

    // pitch: atan2(y, |xz|), roll: atan2(-x, |yz|)
    assign pitch_num = NUM_W'(sample.accel_y);
    assign roll_num  = -NUM_W'(sample.accel_x);

    atpr_tilt #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sample.valid),
        .num       (pitch_num),
        .a         (sample.accel_x),
        .b         (sample.accel_z),
        .out_valid (pitch_valid),
        .angle     (angle.pitch_angle)
    );

    atpr_tilt #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sample.valid),
        .num       (roll_num),
        .a         (sample.accel_y),
        .b         (sample.accel_z),
        .out_valid (roll_valid),
        .angle     (angle.roll_angle)
    );

    assign angle.valid = pitch_valid;

    // both lanes carry the same request
    `AP_IMPL(a_lane_sync, 1'b1, pitch_valid == roll_valid, "tilt lanes out of step")
    // an empty output never blocks a request
    `AP_IMPL(a_ready_free, !angle.valid, sample.ready, "request blocked with output empty")
    // clamp keeps both angles within a quarter turn
    `AP_IMPL(a_pitch_rng, angle.valid, (angle.pitch_angle <= atpr_pkg::ANGLE_LIMIT) && (angle.pitch_angle >= -atpr_pkg::ANGLE_LIMIT), "pitch beyond limit")
    `AP_IMPL(a_roll_rng, angle.valid, (angle.roll_angle <= atpr_pkg::ANGLE_LIMIT) && (angle.roll_angle >= -atpr_pkg::ANGLE_LIMIT), "roll beyond limit")

endmodule

[hdl/atpr_tilt.sv]
// ---------------------------------------------------------------------------
// atpr_tilt
// one tilt lane: atan2(num, sqrt(a*a + b*b)) in hundredths of a degree
// ---------------------------------------------------------------------------
module atpr_tilt #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [atpr_pkg::NUM_W-1:0]   num,
    input  logic signed [atpr_pkg::ACCEL_W-1:0] a,
    input  logic signed [atpr_pkg::ACCEL_W-1:0] b,
    output logic                                out_valid,
    output logic signed [atpr_pkg::ANGLE_W-1:0] angle
);

    localparam int NSTG = (CORDIC_STAGES < atpr_pkg::ATAN_LEN) ?
                          CORDIC_STAGES : atpr_pkg::ATAN_LEN;

    localparam int ACCEL_W = atpr_pkg::ACCEL_W;
    localparam int ANGLE_W = atpr_pkg::ANGLE_W;
    localparam int NUM_W   = atpr_pkg::NUM_W;
    localparam int SQ_W    = atpr_pkg::SQ_W;
    localparam int ROOT_W  = atpr_pkg::ROOT_W;
    localparam int REM_W   = atpr_pkg::REM_W;
    localparam int CRD_W   = atpr_pkg::CRD_W;
    localparam int ACC_W   = atpr_pkg::ACC_W;
    localparam int MAG_W   = atpr_pkg::MAG_W;
    localparam int PROD_W  = atpr_pkg::PROD_W;
    localparam int QUO_W   = atpr_pkg::QUO_W;
    localparam int STEPS   = atpr_pkg::SQRT_STEPS;
    localparam int TRIAL_W = REM_W + 2;

    // squares
    logic signed [2*ACCEL_W-1:0] sqa_full;
    logic signed [2*ACCEL_W-1:0] sqb_full;
    logic [SQ_W-2:0]             sqa_reg, sqb_reg;
    logic signed [NUM_W-1:0]     num0_reg;
    atpr_pkg::tag_t              tag0_reg, tag0_next;

    assign sqa_full = a * a;
    assign sqb_full = b * b;

    always_comb
    begin
        tag0_next.valid    = in_valid;
        tag0_next.num_zero = (num == '0);
        tag0_next.sq_zero  = (a == '0) && (b == '0);
        tag0_next.num_neg  = num[NUM_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag0_reg <= '0;
        end
        else if (en)
        begin
            tag0_reg <= tag0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqa_reg  <= sqa_full[SQ_W-2:0];
            sqb_reg  <= sqb_full[SQ_W-2:0];
            num0_reg <= num;
        end
    end

    // sum of squares, head of the square root pipe
    logic [SQ_W-1:0]         rad0_reg;
    logic signed [NUM_W-1:0] num1_reg;
    atpr_pkg::tag_t          tag1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
        end
        else if (en)
        begin
            tag1_reg <= tag0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad0_reg <= SQ_W'(sqa_reg) + SQ_W'(sqb_reg);
            num1_reg <= num0_reg;
        end
    end

    // digit-by-digit square root of sum << 30, one root bit per stage
    logic [REM_W-1:0]        sq_rem  [0:STEPS];
    logic [ROOT_W-1:0]       sq_root [0:STEPS];
    logic [SQ_W-1:0]         sq_rad  [0:STEPS];
    logic signed [NUM_W-1:0] sq_num  [0:STEPS];
    atpr_pkg::tag_t          sq_tag  [0:STEPS];

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = rad0_reg;
    assign sq_num[0]  = num1_reg;
    assign sq_tag[0]  = tag1_reg;

    for (genvar j = 0; j < STEPS; j++)
    begin : g_sqrt
        logic [TRIAL_W-1:0]      rem_sh, trial;
        logic                    ge;
        logic [REM_W-1:0]        rem_reg, rem_next;
        logic [ROOT_W-1:0]       root_reg, root_next;
        logic [SQ_W-1:0]         rad_reg, rad_next;
        logic signed [NUM_W-1:0] num_reg;
        atpr_pkg::tag_t          tag_reg;

        // bring down the next radicand pair and try the next root bit
        always_comb
        begin
            rem_sh    = {sq_rem[j], sq_rad[j][SQ_W-1 -: 2]};
            trial     = {2'b00, sq_root[j], 2'b01};
            ge        = (rem_sh >= trial);
            rem_next  = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            root_next = {sq_root[j][ROOT_W-2:0], ge};
            rad_next  = {sq_rad[j][SQ_W-3:0], 2'b00};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg <= '0;
            end
            else if (en)
            begin
                tag_reg <= sq_tag[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
                rad_reg  <= rad_next;
                num_reg  <= sq_num[j];
            end
        end

        assign sq_rem[j+1]  = rem_reg;
        assign sq_root[j+1] = root_reg;
        assign sq_rad[j+1]  = rad_reg;
        assign sq_num[j+1]  = num_reg;
        assign sq_tag[j+1]  = tag_reg;
    end

    // vectoring cordic, one micro-rotation per stage
    logic signed [CRD_W-1:0] cx   [0:NSTG];
    logic signed [CRD_W-1:0] cy   [0:NSTG];
    atpr_pkg::udeg_t         cacc [0:NSTG];
    atpr_pkg::tag_t          ctag [0:NSTG];

    assign cx[0]   = CRD_W'(sq_root[STEPS]);
    assign cy[0]   = CRD_W'(sq_num[STEPS]) <<< atpr_pkg::Y_SHIFT;
    assign cacc[0] = '0;
    assign ctag[0] = sq_tag[STEPS];

    for (genvar i = 0; i < NSTG; i++)
    begin : g_cordic
        logic signed [CRD_W-1:0] dx, dy;
        logic signed [CRD_W-1:0] x_reg, x_next, y_reg, y_next;
        atpr_pkg::udeg_t         acc_reg, acc_next;
        atpr_pkg::tag_t          tag_reg;

        // rotate towards y = 0
        always_comb
        begin
            dx = cy[i] >>> i;
            dy = cx[i] >>> i;
            if (!cy[i][CRD_W-1])
            begin
                x_next   = cx[i] + dx;
                y_next   = cy[i] - dy;
                acc_next = cacc[i] + atpr_pkg::ATAN_UDEG[i];
            end
            else
            begin
                x_next   = cx[i] - dx;
                y_next   = cy[i] + dy;
                acc_next = cacc[i] - atpr_pkg::ATAN_UDEG[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg <= '0;
            end
            else if (en)
            begin
                tag_reg <= ctag[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg   <= x_next;
                y_reg   <= y_next;
                acc_reg <= acc_next;
            end
        end

        assign cx[i+1]   = x_reg;
        assign cy[i+1]   = y_reg;
        assign cacc[i+1] = acc_reg;
        assign ctag[i+1] = tag_reg;
    end

    // round: magnitude plus half an lsb
    atpr_pkg::udeg_t    acc_fin, acc_abs;
    logic [ACC_W-1:0]   acc_sum;
    logic               sgna_reg;
    logic [MAG_W-1:0]   maga_reg;
    atpr_pkg::tag_t     taga_reg;

    assign acc_fin = cacc[NSTG];
    assign acc_abs = acc_fin[ACC_W-1] ? -acc_fin : acc_fin;
    assign acc_sum = ACC_W'(acc_abs) + ACC_W'(atpr_pkg::ROUND_HALF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taga_reg <= '0;
        end
        else if (en)
        begin
            taga_reg <= ctag[NSTG];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sgna_reg <= acc_fin[ACC_W-1];
            maga_reg <= acc_sum[MAG_W-1:0];
        end
    end

    // reciprocal multiply for the divide by 10000
    logic [PROD_W-1:0] prodb_reg;
    logic [MAG_W-1:0]  magb_reg;
    logic              sgnb_reg;
    atpr_pkg::tag_t    tagb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tagb_reg <= '0;
        end
        else if (en)
        begin
            tagb_reg <= taga_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prodb_reg <= PROD_W'(maga_reg) * PROD_W'(atpr_pkg::RECIP);
            magb_reg  <= maga_reg;
            sgnb_reg  <= sgna_reg;
        end
    end

    // remainder check, the estimate is low by at most one
    logic [QUO_W-1:0] q_est;
    logic [MAG_W-1:0] q_back, rem_c;
    logic [QUO_W-1:0] qc_reg;
    logic             bumpc_reg;
    logic             sgnc_reg;
    atpr_pkg::tag_t   tagc_reg;

    assign q_est  = prodb_reg[atpr_pkg::RECIP_SHIFT +: QUO_W];
    assign q_back = MAG_W'(q_est) * MAG_W'(atpr_pkg::UDEG_PER_LSB);
    assign rem_c  = magb_reg - q_back;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tagc_reg <= '0;
        end
        else if (en)
        begin
            tagc_reg <= tagb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qc_reg    <= q_est;
            bumpc_reg <= (rem_c >= MAG_W'(atpr_pkg::UDEG_PER_LSB));
            sgnc_reg  <= sgnb_reg;
        end
    end

    // correct, clamp, sign and pick the special cases
    logic [QUO_W-1:0]          q_fin, q_clip;
    logic signed [ANGLE_W-1:0] q_sgn, angle_next;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic                      valid_reg;

    always_comb
    begin
        q_fin  = qc_reg + QUO_W'(bumpc_reg);
        q_clip = (q_fin > QUO_W'(atpr_pkg::ANGLE_LIMIT)) ?
                 QUO_W'(atpr_pkg::ANGLE_LIMIT) : q_fin;
        q_sgn  = ANGLE_W'(q_clip);
        priority if (tagc_reg.num_zero)
        begin
            angle_next = '0;
        end
        else if (tagc_reg.sq_zero)
        begin
            angle_next = tagc_reg.num_neg ? -ANGLE_W'(atpr_pkg::ANGLE_LIMIT) :
                                            ANGLE_W'(atpr_pkg::ANGLE_LIMIT);
        end
        else
        begin
            angle_next = sgnc_reg ? -q_sgn : q_sgn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= tagc_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
        end
    end

    assign out_valid = valid_reg;
    assign angle     = angle_reg;

endmodule

[tb/accel_tilt_pitch_roll_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// accel_tilt_pitch_roll_tb
// self-checking bench for the pitch and roll tilt angle pipeline: a table of
// hand-picked samples, then constrained-by-hand random samples, each request without
// tabled angles predicted by an in-bench square root and cordic model, all matched in order
// against the angles that come out, with random stalls on both channels
// ---------------------------------------------------------------------------
module accel_tilt_pitch_roll_tb;

    localparam int STAGES        = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int N_DIRECTED    = 22;
    localparam int RANDOM_ITEMS  = 1130;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 80;
    localparam longint TILT_LIMIT = 9000;
    localparam longint UDEG_STEP  = 10000;

    typedef logic signed [atpr_pkg::ACCEL_W-1:0] accel_t;
    typedef logic signed [atpr_pkg::ANGLE_W-1:0] angle_t;

    typedef struct packed {
        accel_t x;
        accel_t y;
        accel_t z;
    } sample_t;

    typedef struct packed {
        angle_t pitch;
        angle_t roll;
    } tilt_t;

    typedef struct packed {
        accel_t x;
        accel_t y;
        accel_t z;
        logic   known;
        angle_t pitch;
        angle_t roll;
    } stim_row_t;

    // atan(2^-i) in micro-degrees
    localparam longint ATAN_MICRODEG [ATAN_ENTRIES] = '{
        45000000, 26565051, 14036243, 7125016, 3576334, 1789911,
        895174,   447614,   223811,   111906,  55953,   27976,
        13988,    6994,     3497,     1749,    874,     437,
        219,      109,      55,       27,      14,      7
    };

    localparam accel_t EDGE_VALUES [6] = '{-32768, -32767, -1, 0, 1, 32767};

    // x, y, z, known, pitch, roll
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{0,      0,      0,      1, 0,     0},
        '{0,      100,    0,      1, 9000,  0},
        '{0,      -100,   0,      1, -9000, 0},
        '{-32768, 0,      0,      1, 0,     9000},
        '{32767,  0,      0,      1, 0,     -9000},
        '{0,      32767,  0,      1, 9000,  0},
        '{0,      -32768, 0,      1, -9000, 0},
        '{1,      0,      0,      1, 0,     -9000},
        '{-1,     0,      0,      1, 0,     9000},
        '{0,      0,      32767,  1, 0,     0},
        '{0,      0,      -32768, 1, 0,     0},
        '{-32768, -32768, -32768, 0, 0,     0},
        '{32767,  32767,  32767,  0, 0,     0},
        '{-32768, 32767,  0,      0, 0,     0},
        '{32767,  -32768, -32768, 0, 0,     0},
        '{1,      32767,  0,      0, 0,     0},
        '{0,      -32768, 1,      0, 0,     0},
        '{-1,     1,      -1,     0, 0,     0},
        '{100,    100,    0,      0, 0,     0},
        '{16384,  0,      16384,  0, 0,     0},
        '{-5461,  12345,  -32768, 0, 0,     0},
        '{1,      -1,     32767,  0, 0,     0}
    };

    logic clk = 1'b0;
    logic rst_n;

    atpr_sample_if sample_ch ();
    atpr_angle_if  angle_ch ();

    tilt_t expected_angles [$];
    int    error_count = 0;
    bit    calm = 1'b0;

    accel_tilt_pitch_roll #(
        .CORDIC_STAGES (STAGES)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .angle  (angle_ch)
    );

    // clock
    always #5 clk = ~clk;

    // floor square root, one result bit per pair of input bits
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned probe;
        rem   = v;
        res   = 0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= res + probe)
            begin
                rem = rem - (res + probe);
                res = (res >> 1) + probe;
            end
            else
                res = res >> 1;
            probe = probe >> 2;
        end
        return res;
    endfunction

    // atan2(num, sqrt(a*a + b*b)) in hundredths of a degree
    function automatic angle_t tilt_angle(input longint num, input longint a,
                                          input longint b);
        longint unsigned sq;
        longint xv;
        longint yv;
        longint acc;
        longint dx;
        longint dy;
        longint r;
        int     n;
        sq = longint'(a * a) + longint'(b * b);
        if (num == 0)
            return '0;
        if (sq == 0)
            return (num > 0) ? angle_t'(TILT_LIMIT) : angle_t'(-TILT_LIMIT);

        // vectoring cordic, magnitude at 15 fractional bits
        xv  = longint'(root_floor(sq << 30));
        yv  = num * 32768;
        acc = 0;
        n   = (STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES;
        for (int i = 0; i < n; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv >= 0)
            begin
                xv  = xv + dx;
                yv  = yv - dy;
                acc = acc + ATAN_MICRODEG[i];
            end
            else
            begin
                xv  = xv - dx;
                yv  = yv + dy;
                acc = acc - ATAN_MICRODEG[i];
            end
        end

        // round half away from zero, then clamp
        if (acc >= 0)
            r = (acc + UDEG_STEP / 2) / UDEG_STEP;
        else
            r = -((-acc + UDEG_STEP / 2) / UDEG_STEP);
        if (r > TILT_LIMIT)
            r = TILT_LIMIT;
        if (r < -TILT_LIMIT)
            r = -TILT_LIMIT;
        return angle_t'(r);
    endfunction

    function automatic tilt_t predict_tilt(input sample_t s);
        tilt_t t;
        longint x;
        longint y;
        longint z;
        x = longint'($signed(s.x));
        y = longint'($signed(s.y));
        z = longint'($signed(s.z));
        t.pitch = tilt_angle(y, x, z);
        t.roll  = tilt_angle(-x, y, z);
        return t;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // signed value whose magnitude lies in lo..hi, held inside 16 bits
    function automatic accel_t rand_mag(input int lo, input int hi);
        int m;
        m = $urandom_range(hi, lo);
        if ($urandom_range(1, 0) == 1)
            return accel_t'(-m);
        return (m > 32767) ? accel_t'(32767) : accel_t'(m);
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        int      kind;
        int      axis;
        kind = $urandom_range(99, 0);
        axis = $urandom_range(2, 0);
        s.x  = accel_t'($urandom);
        s.y  = accel_t'($urandom);
        s.z  = accel_t'($urandom);
        if (kind < 40)
        begin
            // full range as drawn
        end
        else if (kind < 55)
        begin
            s.x = rand_mag(0, 64);
            s.y = rand_mag(0, 64);
            s.z = rand_mag(0, 64);
        end
        else if (kind < 68 || kind >= 88)
        begin
            // one dominant axis: near rest, or close to the clamp
            s.x = (kind < 68) ? rand_mag(0, 600) : rand_mag(0, 3);
            s.y = (kind < 68) ? rand_mag(0, 600) : rand_mag(0, 3);
            s.z = (kind < 68) ? rand_mag(0, 600) : rand_mag(0, 3);
            unique case (axis)
                0: s.x = rand_mag(1000, 32768);
                1: s.y = rand_mag(1000, 32768);
                default: s.z = rand_mag(1000, 32768);
            endcase
        end
        else if (kind < 78)
        begin
            if ($urandom_range(1, 0) == 1) s.x = '0;
            if ($urandom_range(1, 0) == 1) s.y = '0;
            if ($urandom_range(1, 0) == 1) s.z = '0;
        end
        else
        begin
            s.x = EDGE_VALUES[$urandom_range(5, 0)];
            s.y = EDGE_VALUES[$urandom_range(5, 0)];
            s.z = EDGE_VALUES[$urandom_range(5, 0)];
        end
        return s;
    endfunction

    // one request: optional idle, then hold until accepted
    task automatic send_sample(input sample_t s, input logic known, input tilt_t typed);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.accel_x <= s.x;
        sample_ch.accel_y <= s.y;
        sample_ch.accel_z <= s.z;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        expected_angles.push_back(known ? typed : predict_tilt(s));
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_angles.size() != 0);
    endtask

    task automatic check_angle(input string label, input angle_t want, input angle_t got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    // result checking, in order of acceptance
    always @(posedge clk)
    begin : angle_check
        tilt_t want;
        if (rst_n === 1'b1 && angle_ch.valid === 1'b1 && angle_ch.ready === 1'b1)
        begin
            if (expected_angles.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result: pitch %0d, roll %0d", $time,
                         angle_ch.pitch_angle, angle_ch.roll_angle);
            end
            else
            begin
                want = expected_angles.pop_front();
                check_angle("pitch", want.pitch, angle_ch.pitch_angle);
                check_angle("roll", want.roll, angle_ch.roll_angle);
            end
        end
    end

    // result side back-pressure
    initial
    begin : angle_sink
        int g;
        angle_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            angle_ch.ready <= 1'b1;
            repeat ($urandom_range(20, 1)) @(posedge clk);
            g = pick_gap();
            if (g > 0)
            begin
                angle_ch.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    initial
    begin : watchdog
        int idle;
        idle = 0;
        wait (rst_n === 1'b1);
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
                (angle_ch.valid === 1'b1 && angle_ch.ready === 1'b1))
                idle = 0;
            else
                idle++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        stim_row_t row;
        tilt_t     typed;
        sample_t   s;
        rst_n             <= 1'b0;
        sample_ch.valid   <= 1'b0;
        sample_ch.accel_x <= '0;
        sample_ch.accel_y <= '0;
        sample_ch.accel_z <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row         = DIRECTED_ROWS[i];
            s.x         = row.x;
            s.y         = row.y;
            s.z         = row.z;
            typed.pitch = row.pitch;
            typed.roll  = row.roll;
            send_sample(s, row.known, typed);
        end
        drain_results();

        // random samples, with a stretch of no idling and a mid-run drain
        typed = '0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 400)
                calm = 1'b1;
            if (i == 560)
                calm = 1'b0;
            if (i == 750)
                drain_results();
            send_sample(random_sample(), 1'b0, typed);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/atpr_pkg.sv
hdl/atpr_if.sv
hdl/atpr_tilt.sv
hdl/accel_tilt_pitch_roll.sv
tb/accel_tilt_pitch_roll_tb.sv
